/* hdl/sorted_value_table_unit_assert.svh */
// Assertion macros shared by the sorted value table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SORTED_VALUE_TABLE_UNIT_ASSERT_SVH
`define SORTED_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVT_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sorted value table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sorted value table check failed");

`endif

/* hdl/svt_pkg.sv */
// Package for the sorted value table: request and status codes, cell command.
// Used by svt_cell and sorted_value_table_unit; depends on nothing.
package svt_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 4;
  localparam int unsigned CountOutW = 5;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } svt_cmd_t;

endpackage

/* hdl/svt_cell.sv */
// One cell of the sorted row: holds a single entry and shifts it to or from
// its neighbors on insert and delete. Depends on svt_pkg.
module svt_cell
  import svt_pkg::*;
(
  input  logic                     clk_i,
  input  svt_cmd_t                 cmd_i,
  input  logic                     occ_left_i,   // left neighbor holds an entry
  input  logic                     occ_self_i,   // this cell holds an entry
  input  logic                     occ_right_i,  // right neighbor holds an entry
  input  logic                     left_gt_i,    // left neighbor entry above value
  input  logic signed [ValueW-1:0] left_entry_i,
  input  logic signed [ValueW-1:0] right_entry_i,
  output logic                     gt_o,
  output logic                     hit_o,
  output logic signed [ValueW-1:0] entry_o
);

  logic signed [ValueW-1:0] entry_q;
  logic signed [ValueW-1:0] entry_d;
  logic                     gt;
  logic                     ge;

  assign gt = entry_q > cmd_i.value;
  assign ge = entry_q >= cmd_i.value;

  assign gt_o    = occ_self_i & gt;
  assign hit_o   = occ_self_i & (entry_q == cmd_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    priority if (cmd_i.ins_en) begin
      // shift right behind the insertion point, drop the value at it
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (occ_left_i && (gt || !occ_self_i)) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del_en) begin
      // close the gap from the first equal entry onward
      if (occ_right_i && ge) begin
        entry_d = right_entry_i;
      end
    end else begin
      // hold the entry when the row is idle
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hdl/sorted_value_table_unit.sv */
// Sorted value table: the result is valid in the cycle after the input transaction.
// Throughput one request per cycle while results are taken; every request settles in a single pass
// through the row of compare-and-shift cells. A result waiting for m_axis_tready
// holds the input off; a result taken in the same cycle lets the next request in.
// Reset (rst_ni low, asynchronous) empties the table and drops any pending
// result; entry storage is not cleared, only entries below the count are read.
`include "sorted_value_table_unit_assert.svh"

module sorted_value_table_unit
  import svt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] index, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [33:2] read_value,
                                      // [38:34] entry_count, rest zero
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned ReadN  = (CAPACITY < (1 << IndexW)) ? CAPACITY : (1 << IndexW);

  // Request fields.
  mode_e                    mode;
  logic signed [ValueW-1:0] req_value;
  logic [IndexW-1:0]        req_index;
  logic                     accept;

  assign mode      = mode_e'(s_axis_tuser);
  assign req_value = s_axis_tdata[ValueW-1:0];
  assign req_index = s_axis_tdata[ValueW+IndexW-1:ValueW];
  assign accept    = s_axis_tvalid & s_axis_tready;

  // Table occupancy.
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              full;
  logic              found;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] hit_vec;
  logic signed [ValueW-1:0] entry_w [CAPACITY];

  assign full  = (count_q == CountW'(CAPACITY));
  assign found = |hit_vec;

  // Thermometer of occupied cells, one compare per cell.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CountW'(i) < count_q);
    end
  end

  // Broadcast command: hold the row unless the request changes it.
  svt_cmd_t cmd;
  always_comb begin
    cmd.value  = req_value;
    cmd.ins_en = accept && (mode == MODE_INSERT) && !full;
    cmd.del_en = accept && (mode == MODE_DELETE) && found;
  end

  // Row of cells, each talking only to its two neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     occ_left;
    logic                     occ_right;
    logic                     left_gt;
    logic signed [ValueW-1:0] left_entry;
    logic signed [ValueW-1:0] right_entry;

    if (g == 0) begin : g_first
      assign occ_left   = 1'b1;
      assign left_gt    = 1'b0;
      assign left_entry = '0;
    end else begin : g_inner_l
      assign occ_left   = occ[g-1];
      assign left_gt    = gt_vec[g-1];
      assign left_entry = entry_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign occ_right   = 1'b0;
      assign right_entry = '0;
    end else begin : g_inner_r
      assign occ_right   = occ[g+1];
      assign right_entry = entry_w[g+1];
    end

    svt_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_left_i    (occ_left),
      .occ_self_i    (occ[g]),
      .occ_right_i   (occ_right),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .gt_o          (gt_vec[g]),
      .hit_o         (hit_vec[g]),
      .entry_o       (entry_w[g])
    );
  end

  // Read port over the positions the index field can reach.
  logic                     read_ok;
  logic signed [ValueW-1:0] read_entry;
  logic [CountW+IndexW-1:0] index_ext;
  logic [CountW+IndexW-1:0] count_ext;

  assign index_ext = {{CountW{1'b0}}, req_index};
  assign count_ext = {{IndexW{1'b0}}, count_q};
  assign read_ok   = index_ext < count_ext;

  always_comb begin
    read_entry = '0;
    for (int i = 0; i < ReadN; i++) begin
      if (req_index == IndexW'(i)) begin
        read_entry = entry_w[i];
      end
    end
  end

  // Next count and result of this request.
  status_e                  status;
  logic signed [ValueW-1:0] rd_value;

  always_comb begin
    count_d  = count_q;
    status   = ST_OK;
    rd_value = '0;
    unique case (mode)
      MODE_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      MODE_DELETE: begin
        if (found) begin
          count_d = count_q - CountW'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      MODE_READ: begin
        if (read_ok) begin
          rd_value = read_entry;
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Result register: accept a new request whenever the slot is empty or frees this cycle.
  logic                       out_valid_q;
  logic [39:0]                out_data_q;
  logic [39:0]                out_data_d;
  logic [CountW+CountOutW-1:0] count_out_ext;

  assign count_out_ext = {{CountOutW{1'b0}}, count_d};
  assign out_data_d    = {1'b0, count_out_ext[CountOutW-1:0], rd_value, status};
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks on the table's own bookkeeping.
  `SVT_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CountW'(CAPACITY))
  `SVT_ASSERT_NOW(a_sorted_head, clk_i, rst_ni, occ[1], entry_w[0] <= entry_w[1])
  `SVT_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni,
    accept && (mode == MODE_CLEAR), count_q == '0)
  `SVT_ASSERT_NEXT(a_full_keeps_count, clk_i, rst_ni,
    accept && (mode == MODE_INSERT) && full, count_q == CountW'(CAPACITY))

endmodule

/* verif/tb_sorted_value_table_unit.sv */
// Testbench for sorted_value_table_unit: drives insert, delete, clear and read requests
// with random bursts and output stalls, and checks every result against a predictor.
// Depends on svt_pkg and the sorted_value_table_unit RTL.
`timescale 1ns / 1ps

module tb_sorted_value_table_unit;
  import svt_pkg::*;

  localparam int unsigned CAPACITY  = 16;
  // Cycles without any transaction before the run is declared hung.
  localparam int          IdleLimit = 2000;
  localparam int          MaxPrints = 30;

  typedef struct packed {
    status_e     status;
    logic [31:0] read_value;
    logic [4:0]  entry_count;
  } table_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [31:0] value, [35:32] index, rest zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [1:0] status, [33:2] read_value, [38:34] entry_count

  sorted_value_table_unit #(.CAPACITY(CAPACITY)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the table, kept in ascending signed order.
  logic signed [31:0] table_vals [CAPACITY];
  int                 table_len = 0;
  table_result_t      pending_results [$];

  int error_count = 0;
  int idle_cycles = 0;
  int mode_seen   [4] = '{default: 0};
  int status_seen [4] = '{default: 0};

  // Sender burst shaping and receiver stall pattern state.
  int burst_left   = 8;
  int ready_style  = 0;
  int style_cycles = 0;
  int stall_hold   = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrints)
      $display("[%0t] mismatch %0d, %s: got %0h, expected %0h",
               $realtime, error_count, what, got, want);
  endtask

  // Apply one request to the shadow table and return the result it must produce.
  function automatic table_result_t apply_request(mode_e mode, logic signed [31:0] value,
                                                  logic [3:0] index);
    table_result_t res;
    int            pos;
    res.status     = ST_OK;
    res.read_value = '0;
    pos = 0;
    case (mode)
      MODE_INSERT: begin
        if (table_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // New value goes after every equal one.
          while (pos < table_len && table_vals[pos] <= value) pos++;
          for (int k = table_len; k > pos; k--) table_vals[k] = table_vals[k-1];
          table_vals[pos] = value;
          table_len++;
        end
      end
      MODE_DELETE: begin
        while (pos < table_len && table_vals[pos] != value) pos++;
        if (pos >= table_len) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos; k + 1 < table_len; k++) table_vals[k] = table_vals[k+1];
          table_len--;
        end
      end
      MODE_CLEAR: begin
        table_len = 0;
      end
      default: begin
        if (index < table_len) res.read_value = table_vals[index];
        else res.status = ST_RANGE;
      end
    endcase
    res.entry_count = table_len[4:0];
    mode_seen[mode]++;
    status_seen[res.status]++;
    return res;
  endfunction

  // Predict on every input transaction, then compare every output transaction
  // against the oldest prediction. Both sides sample values from before the edge.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(apply_request(mode_e'(s_axis_tuser), s_axis_tdata[31:0],
                                                s_axis_tdata[35:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata[31:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch("status", m_axis_tdata[1:0], want.status);
          if (m_axis_tdata[33:2] != want.read_value)
            report_mismatch("read_value", m_axis_tdata[33:2], want.read_value);
          if (m_axis_tdata[38:34] != want.entry_count)
            report_mismatch("entry_count", m_axis_tdata[38:34], want.entry_count);
        end
      end
    end
  end

  // Receiver: pick at random, time and again, among always ready, light stalls,
  // heavy stalls and long stall runs.
  always @(posedge clk_i) begin
    if (style_cycles == 0) begin
      ready_style  = $urandom_range(0, 3);
      style_cycles = 96;
    end
    style_cycles--;
    case (ready_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 9) < 3);
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_hold = $urandom_range(4, 12);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: abort when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Send one request and hold it until accepted; then maybe idle before the next.
  task automatic send_request(input mode_e mode, input logic [31:0] value,
                              input logic [3:0] index);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, index, value};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Most often values already stored (delete hits, duplicates), then small values
  // around zero, the signed extremes, and full-range noise.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && table_len > 0) return table_vals[$urandom_range(0, table_len - 1)];
    if (sel < 7) return 32'($urandom_range(0, 6)) - 32'd3;
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic test_empty_table();
    send_request(MODE_READ, 32'h0, 4'd0);
    send_request(MODE_READ, 32'hFFFF_FFFF, 4'd15);
    send_request(MODE_DELETE, 32'h0, 4'd0);
    send_request(MODE_CLEAR, 32'h0, 4'd0);
  endtask

  task automatic test_signed_order();
    send_request(MODE_INSERT, 32'h7FFF_FFFF, 4'd0);
    send_request(MODE_INSERT, 32'h8000_0000, 4'd0);
    send_request(MODE_INSERT, 32'h0000_0000, 4'd0);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 4'd0);
    send_request(MODE_INSERT, 32'h0000_0001, 4'd0);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 4'd0);   // duplicate lands after its twin
    send_request(MODE_READ, 32'h0, 4'd0);
    send_request(MODE_READ, 32'h0, 4'd2);
    send_request(MODE_READ, 32'h0, 4'd5);
    send_request(MODE_READ, 32'h0, 4'd6);             // index equal to the count
    send_request(MODE_DELETE, 32'hFFFF_FFFF, 4'd0);   // first of the equal pair
    send_request(MODE_DELETE, 32'd42, 4'd0);          // absent value
    send_request(MODE_READ, 32'h0, 4'd1);
    send_request(MODE_CLEAR, 32'h0, 4'd0);
  endtask

  // Fill past capacity so inserts hit the full table, read back, then drain
  // by deleting stored values with some misses mixed in.
  task automatic test_fill_and_drain(input int rounds);
    int guard;
    for (int r = 0; r < rounds; r++) begin
      send_request(MODE_CLEAR, $urandom, 4'($urandom_range(0, 15)));
      repeat (CAPACITY + $urandom_range(1, 3))
        send_request(MODE_INSERT, pick_value(), 4'($urandom_range(0, 15)));
      repeat (6)
        send_request(MODE_READ, $urandom, 4'($urandom_range(0, 15)));
      guard = 0;
      while (table_len > 0 && guard < 40) begin
        send_request(MODE_DELETE, ($urandom_range(0, 4) == 0) ? $urandom : pick_value(),
                     4'($urandom_range(0, 15)));
        guard++;
      end
      send_request(MODE_READ, $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  // Random mix whose mode weights change every 40 requests: insert-heavy,
  // delete-heavy, read-heavy or balanced; clear stays rare.
  task automatic test_random_mix(input int count);
    int    bias;
    int    roll;
    mode_e mode;
    bias = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) bias = $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 3) mode = MODE_CLEAR;
      else if (roll < (bias == 0 ? 70 : 35)) mode = MODE_INSERT;
      else if (roll < (bias == 1 ? 85 : 65)) mode = MODE_DELETE;
      else mode = (bias == 2 || roll >= 80) ? MODE_READ : MODE_INSERT;
      send_request(mode, (mode == MODE_INSERT || mode == MODE_DELETE) ? pick_value() : $urandom,
                   4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    int drain_wait;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_signed_order();
    test_fill_and_drain(5);
    test_random_mix(230);
    s_axis_tvalid <= 1'b0;

    // Let the last results come out, then keep watching for stray outputs.
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < IdleLimit) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);

    $display("requests: %0d insert, %0d delete, %0d clear, %0d read",
             mode_seen[MODE_INSERT], mode_seen[MODE_DELETE], mode_seen[MODE_CLEAR],
             mode_seen[MODE_READ]);
    $display("outcomes: %0d ok, %0d not found, %0d full, %0d out of range; %0d errors",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
             status_seen[ST_RANGE], error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sorted_value_table_unit.f */
+incdir+hdl
hdl/svt_pkg.sv
hdl/svt_cell.sv
hdl/sorted_value_table_unit.sv
verif/tb_sorted_value_table_unit.sv
